// ----- rtl/nme_pkg.sv -----
`default_nettype none

package nme_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MIN_Y = 3'd1,
        REG_BOX_MIN_Z = 3'd2,
        REG_BOX_MAX_X = 3'd3,
        REG_BOX_MAX_Y = 3'd4,
        REG_BOX_MAX_Z = 3'd5,
        REG_LEVELS    = 3'd6
    } reg_idx_t;

    localparam int unsigned REG_IDX_BITS = 3;
    localparam int unsigned LEVELS_BITS  = 5;
    localparam int unsigned CODE_BITS    = 63;
    localparam int unsigned NUM_AXES     = 3;
    localparam logic [LEVELS_BITS-1:0] LEVELS_RESET = 5'd15;

endpackage

`default_nettype wire

// ----- rtl/normalized_morton_encoder_3d.sv -----
`default_nettype none

// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------
// in       | in_valid / in_ready    | pos_x, pos_y, pos_z
// out      | out_valid / out_ready  | grid_code
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle sustained while the output is not stalled; the stages are: offset
// clamp, one multiply, one cell per quotient bit, then the interleave register.
// The row of divider cells sets the latency; all stages advance together.
// Reset loads the box [0, 1.0] on every axis and 15 levels; cfg_ready stays high.
// A stalled output holds the whole row, and in_ready drops in the same cycle.

module normalized_morton_encoder_3d #(
    parameter int unsigned COORD_BITS    = 32,
    parameter int unsigned FRACTION_BITS = 16,
    parameter int unsigned MAX_LEVELS    = 21
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [COORD_BITS-1:0]              pos_x,
    input  wire logic [COORD_BITS-1:0]              pos_y,
    input  wire logic [COORD_BITS-1:0]              pos_z,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [nme_pkg::CODE_BITS-1:0]      grid_code,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [nme_pkg::REG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [COORD_BITS-1:0]              cfg_data
);

    localparam int unsigned W = COORD_BITS + MAX_LEVELS;
    localparam logic [COORD_BITS-1:0] MAX_RESET = COORD_BITS'(64'd1 << FRACTION_BITS);
    localparam logic [nme_pkg::LEVELS_BITS-1:0] LEVELS_CAP =
        nme_pkg::LEVELS_BITS'(MAX_LEVELS);

    logic [COORD_BITS-1:0]            min_reg [nme_pkg::NUM_AXES];
    logic [COORD_BITS-1:0]            max_reg [nme_pkg::NUM_AXES];
    logic [nme_pkg::LEVELS_BITS-1:0]  levels_reg;
    logic [MAX_LEVELS-1:0]            top_reg;
    logic [MAX_LEVELS-1:0]            top_next;
    logic [nme_pkg::LEVELS_BITS-1:0]  lv;
    logic [COORD_BITS-1:0]            pos_a   [nme_pkg::NUM_AXES];
    logic [COORD_BITS-1:0]            extent  [nme_pkg::NUM_AXES];
    logic [W-1:0]                     work    [nme_pkg::NUM_AXES][MAX_LEVELS+1];
    logic                             adv;
    logic                             v_prep_reg;
    logic                             v_mul_reg;
    logic [MAX_LEVELS-1:0]            cv_reg;
    logic                             out_valid_reg;
    logic [nme_pkg::CODE_BITS-1:0]    code_reg;
    logic [nme_pkg::CODE_BITS-1:0]    code_next;

    assign pos_a[0] = pos_x;
    assign pos_a[1] = pos_y;
    assign pos_a[2] = pos_z;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < nme_pkg::NUM_AXES; a++)
            begin
                min_reg[a] <= '0;
                max_reg[a] <= MAX_RESET;
            end
            levels_reg <= nme_pkg::LEVELS_RESET;
        end
        else if (cfg_valid)
        begin
            case (nme_pkg::reg_idx_t'(cfg_index))
                nme_pkg::REG_BOX_MIN_X: min_reg[0] <= cfg_data;
                nme_pkg::REG_BOX_MIN_Y: min_reg[1] <= cfg_data;
                nme_pkg::REG_BOX_MIN_Z: min_reg[2] <= cfg_data;
                nme_pkg::REG_BOX_MAX_X: max_reg[0] <= cfg_data;
                nme_pkg::REG_BOX_MAX_Y: max_reg[1] <= cfg_data;
                nme_pkg::REG_BOX_MAX_Z: max_reg[2] <= cfg_data;
                nme_pkg::REG_LEVELS:    levels_reg <= cfg_data[nme_pkg::LEVELS_BITS-1:0];
                default:                ;
            endcase
        end
    end

    // Saturate levels and build the scale 2^L - 1
    assign lv = (levels_reg > LEVELS_CAP) ? LEVELS_CAP : levels_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            top_next[i] = (nme_pkg::LEVELS_BITS'(i) < lv);
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    // Advance the whole row unless a finished code is held at the output
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    for (genvar a = 0; a < nme_pkg::NUM_AXES; a++)
    begin : g_axis
        nme_axis_front #(
            .COORD_BITS (COORD_BITS),
            .MAX_LEVELS (MAX_LEVELS)
        ) u_front (
            .clk     (clk),
            .en      (adv),
            .pos     (pos_a[a]),
            .box_min (min_reg[a]),
            .box_max (max_reg[a]),
            .top     (top_reg),
            .extent  (extent[a]),
            .prod    (work[a][0])
        );

        for (genvar k = 0; k < MAX_LEVELS; k++)
        begin : g_cell
            nme_div_cell #(
                .COORD_BITS (COORD_BITS),
                .MAX_LEVELS (MAX_LEVELS)
            ) u_cell (
                .clk      (clk),
                .en       (adv),
                .extent   (extent[a]),
                .work_in  (work[a][k]),
                .work_out (work[a][k+1])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_prep_reg    <= 1'b0;
            v_mul_reg     <= 1'b0;
            cv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_prep_reg <= in_valid;
            v_mul_reg  <= v_prep_reg;
            cv_reg[0]  <= v_mul_reg;
            for (int k = 1; k < MAX_LEVELS; k++)
            begin
                cv_reg[k] <= cv_reg[k-1];
            end
            out_valid_reg <= cv_reg[MAX_LEVELS-1];
        end
    end

    // Interleave: x to bit 3i, y to 3i+1, z to 3i+2
    always_comb
    begin
        code_next = '0;
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            code_next[3*i]   = work[0][MAX_LEVELS][i];
            code_next[3*i+1] = work[1][MAX_LEVELS][i];
            code_next[3*i+2] = work[2][MAX_LEVELS][i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            code_reg <= code_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign grid_code = code_reg;

endmodule

`default_nettype wire

// ----- rtl/nme_axis_front.sv -----
`default_nettype none

module nme_axis_front #(
    parameter int unsigned COORD_BITS = 32,
    parameter int unsigned MAX_LEVELS = 21
) (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic [COORD_BITS-1:0]            pos,
    input  wire logic [COORD_BITS-1:0]            box_min,
    input  wire logic [COORD_BITS-1:0]            box_max,
    input  wire logic [MAX_LEVELS-1:0]            top,
    output logic      [COORD_BITS-1:0]            extent,
    output logic      [COORD_BITS+MAX_LEVELS-1:0] prod
);

    localparam logic [COORD_BITS-1:0] SIGN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] ONE  = {{(COORD_BITS-1){1'b0}}, 1'b1};

    logic [COORD_BITS-1:0]            r_reg;
    logic [COORD_BITS-1:0]            r_next;
    logic [COORD_BITS-1:0]            d_reg;
    logic [COORD_BITS-1:0]            d_next;
    logic [COORD_BITS+MAX_LEVELS-1:0] prod_reg;
    logic [COORD_BITS+MAX_LEVELS-1:0] prod_next;
    logic [COORD_BITS-1:0]            p_b;
    logic [COORD_BITS-1:0]            mn_b;
    logic [COORD_BITS-1:0]            mx_b;
    logic [COORD_BITS-1:0]            diff;

    // Offset binary keeps the signed order under unsigned compares
    assign p_b  = pos ^ SIGN;
    assign mn_b = box_min ^ SIGN;
    assign mx_b = box_max ^ SIGN;

    // Extent floors at one LSB for an empty or inverted box
    assign r_next = (mx_b > mn_b) ? (mx_b - mn_b) : ONE;

    assign diff = p_b - mn_b;

    // Clamp the offset to [0, extent] so the divider never sees a ratio above one
    always_comb
    begin
        if (p_b <= mn_b)
        begin
            d_next = '0;
        end
        else if (diff >= r_next)
        begin
            d_next = r_next;
        end
        else
        begin
            d_next = diff;
        end
    end

    assign prod_next = (COORD_BITS+MAX_LEVELS)'(d_reg) * (COORD_BITS+MAX_LEVELS)'(top);

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= d_next;
            prod_reg <= prod_next;
        end
    end

    assign extent = r_reg;
    assign prod   = prod_reg;

endmodule

`default_nettype wire

// ----- rtl/nme_div_cell.sv -----
`default_nettype none

module nme_div_cell #(
    parameter int unsigned COORD_BITS = 32,
    parameter int unsigned MAX_LEVELS = 21
) (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic [COORD_BITS-1:0]            extent,
    input  wire logic [COORD_BITS+MAX_LEVELS-1:0] work_in,
    output logic      [COORD_BITS+MAX_LEVELS-1:0] work_out
);

    localparam int unsigned W = COORD_BITS + MAX_LEVELS;

    logic [W-1:0]          work_reg;
    logic [W-1:0]          work_next;
    logic [W:0]            shifted;
    logic [COORD_BITS:0]   part;
    logic [COORD_BITS:0]   part_sub;
    logic [MAX_LEVELS-1:0] low;

    // One restoring step: remainder sits on top, quotient bits fill in from below
    assign shifted  = {work_in, 1'b0};
    assign part     = shifted[W:MAX_LEVELS];
    assign part_sub = part - {1'b0, extent};

    always_comb
    begin
        low = shifted[MAX_LEVELS-1:0];
        if (part >= {1'b0, extent})
        begin
            low[0]    = 1'b1;
            work_next = {part_sub[COORD_BITS-1:0], low};
        end
        else
        begin
            work_next = {part[COORD_BITS-1:0], low};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg <= work_next;
        end
    end

    assign work_out = work_reg;

endmodule

`default_nettype wire

// ----- rtl/nme_checker.sv -----
`default_nettype none

module nme_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [nme_pkg::CODE_BITS-1:0] grid_code,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(grid_code))
        else $error("stalled result changed or dropped");

    // Drop in_ready while the output is stalled
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while output stalled");

    // Accept requests whenever the output register is free
    a_free_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write not taken");

endmodule

bind normalized_morton_encoder_3d nme_checker u_nme_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int unsigned GRID_MAX_LEVELS = 21;
    localparam logic [nme_pkg::REG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam logic [31:0] COORD_MIN = 32'h8000_0000;
    localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic out_valid;
    logic out_ready;
    logic [nme_pkg::CODE_BITS-1:0] grid_code;
    logic cfg_valid;
    logic cfg_ready;
    logic [nme_pkg::REG_IDX_BITS-1:0] cfg_index;
    logic [31:0] cfg_data;

    // Shadow of the box and level registers
    logic [31:0] box_lo [3];
    logic [31:0] box_hi [3];
    logic [nme_pkg::LEVELS_BITS-1:0] grid_levels;

    logic [nme_pkg::CODE_BITS-1:0] codes_due [$];
    bit src_idle;
    bit sink_idle;
    int unsigned errors;
    int unsigned points_sent;
    int unsigned codes_seen;
    int unsigned reg_writes;

    normalized_morton_encoder_3d u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .grid_code   (grid_code),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic log_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Grid cell on one axis: floor(d * top / r) with the offset clamped to the box
    function automatic logic [20:0] grid_of(input logic [31:0] pos, input logic [31:0] lo,
                                            input logic [31:0] hi, input logic [20:0] top);
        logic [63:0] p;
        logic [63:0] mn;
        logic [63:0] mx;
        logic [63:0] r;
        logic [63:0] d;
        p = {32'd0, pos ^ COORD_MIN};
        mn = {32'd0, lo ^ COORD_MIN};
        mx = {32'd0, hi ^ COORD_MIN};
        r = (mx > mn) ? mx - mn : 64'd1;
        if (p <= mn)
            return '0;
        d = p - mn;
        if (d >= r)
            return top;
        return 21'((d * {43'd0, top}) / r);
    endfunction

    function automatic logic [nme_pkg::CODE_BITS-1:0] morton_of(input logic [31:0] x,
                                                                input logic [31:0] y,
                                                                input logic [31:0] z);
        logic [nme_pkg::LEVELS_BITS-1:0] lv;
        logic [20:0] top;
        logic [20:0] gx;
        logic [20:0] gy;
        logic [20:0] gz;
        logic [nme_pkg::CODE_BITS-1:0] code;
        lv = (grid_levels > nme_pkg::LEVELS_BITS'(GRID_MAX_LEVELS)) ?
             nme_pkg::LEVELS_BITS'(GRID_MAX_LEVELS) : grid_levels;
        top = 21'((64'd1 << lv) - 64'd1);
        gx = grid_of(x, box_lo[0], box_hi[0], top);
        gy = grid_of(y, box_lo[1], box_hi[1], top);
        gz = grid_of(z, box_lo[2], box_hi[2], top);
        code = '0;
        for (int i = 0; i < GRID_MAX_LEVELS; i++)
        begin
            if (i < lv)
            begin
                code[3*i]     = gx[i];
                code[3*i + 1] = gy[i];
                code[3*i + 2] = gz[i];
            end
        end
        return code;
    endfunction

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        do @(posedge clk); while (!in_ready);
        codes_due = {codes_due, morton_of(x, y, z)};
        points_sent++;
    endtask

    // Hold off new requests until every pending code is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (codes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [nme_pkg::REG_IDX_BITS-1:0] idx,
                             input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            nme_pkg::REG_BOX_MIN_X: box_lo[0] = data;
            nme_pkg::REG_BOX_MIN_Y: box_lo[1] = data;
            nme_pkg::REG_BOX_MIN_Z: box_lo[2] = data;
            nme_pkg::REG_BOX_MAX_X: box_hi[0] = data;
            nme_pkg::REG_BOX_MAX_Y: box_hi[1] = data;
            nme_pkg::REG_BOX_MAX_Z: box_hi[2] = data;
            nme_pkg::REG_LEVELS:    grid_levels = data[nme_pkg::LEVELS_BITS-1:0];
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_box(input logic [31:0] lo, input logic [31:0] hi);
        cfg_write(nme_pkg::REG_BOX_MIN_X, lo);
        cfg_write(nme_pkg::REG_BOX_MIN_Y, lo);
        cfg_write(nme_pkg::REG_BOX_MIN_Z, lo);
        cfg_write(nme_pkg::REG_BOX_MAX_X, hi);
        cfg_write(nme_pkg::REG_BOX_MAX_Y, hi);
        cfg_write(nme_pkg::REG_BOX_MAX_Z, hi);
    endtask

    // Mostly points around the box, some on its edges, some anywhere
    function automatic logic [31:0] point_near(input logic [31:0] lo, input logic [31:0] hi);
        longint lo_s;
        longint hi_s;
        longint span;
        longint p;
        logic [63:0] rnd;
        int unsigned pick;
        lo_s = longint'($signed(lo));
        hi_s = longint'($signed(hi));
        span = hi_s - lo_s;
        if (span < 16)
            span = 16;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return $urandom;
        if (pick < 30)
        begin
            case ($urandom_range(0, 5))
                0: p = lo_s - 1;
                1: p = lo_s;
                2: p = lo_s + 1;
                3: p = hi_s - 1;
                4: p = hi_s;
                default: p = hi_s + 1;
            endcase
        end
        else
        begin
            rnd = {$urandom, $urandom};
            p = lo_s + longint'(rnd % 64'(span + span / 4)) - span / 8;
        end
        if (p < longint'($signed(COORD_MIN)))
            p = longint'($signed(COORD_MIN));
        if (p > longint'($signed(COORD_MAX)))
            p = longint'($signed(COORD_MAX));
        return p[31:0];
    endfunction

    task automatic rand_bounds(output logic [31:0] lo, output logic [31:0] hi);
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                if ($signed(a) > $signed(b))
                begin
                    lo = b;
                    hi = a;
                end
                else
                begin
                    lo = a;
                    hi = b;
                end
            end
            4, 5:
            begin
                lo = a;
                hi = a + $urandom_range(1, 300);
            end
            6:
            begin
                lo = COORD_MIN;
                hi = COORD_MAX;
            end
            7:
            begin
                lo = a;
                hi = a;
            end
            8:
            begin
                lo = a;
                hi = a - $urandom_range(1, 1000);
            end
            default:
            begin
                lo = ($urandom_range(0, 20) - 10) * ONE_Q16;
                hi = lo + $urandom_range(1, 8) * ONE_Q16;
            end
        endcase
    endtask

    task automatic rand_settings();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [nme_pkg::LEVELS_BITS-1:0] lv;
        rand_bounds(lo, hi);
        cfg_write(nme_pkg::REG_BOX_MIN_X, lo);
        cfg_write(nme_pkg::REG_BOX_MAX_X, hi);
        rand_bounds(lo, hi);
        cfg_write(nme_pkg::REG_BOX_MIN_Y, lo);
        cfg_write(nme_pkg::REG_BOX_MAX_Y, hi);
        rand_bounds(lo, hi);
        cfg_write(nme_pkg::REG_BOX_MIN_Z, lo);
        cfg_write(nme_pkg::REG_BOX_MAX_Z, hi);
        case ($urandom_range(0, 7))
            0: lv = '0;
            1: lv = 5'd1;
            2: lv = nme_pkg::LEVELS_BITS'(GRID_MAX_LEVELS);
            3: lv = nme_pkg::LEVELS_BITS'($urandom_range(22, 31));
            default: lv = nme_pkg::LEVELS_BITS'($urandom_range(1, 21));
        endcase
        // upper data bits must be dropped by the register
        cfg_write(nme_pkg::REG_LEVELS, ($urandom & ~32'h1F) | {27'd0, lv});
        if ($urandom_range(0, 3) == 0)
            cfg_write(REG_UNUSED, $urandom);
    endtask

    task automatic test_unit_box();
        drain();
        send_point(32'd0, 32'd0, 32'd0);
        send_point(ONE_Q16, ONE_Q16, ONE_Q16);
        send_point(32'h0000_8000, 32'h0000_4000, 32'h0000_C000);
        send_point(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0001_0001);
        send_point(COORD_MAX, COORD_MIN, 32'd1);
        send_point(32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    task automatic test_levels();
        drain();
        cfg_write(nme_pkg::REG_LEVELS, 32'd21);
        send_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        send_point(32'h0000_3039, 32'h0000_D431, 32'h0000_FFFF);
        drain();
        cfg_write(nme_pkg::REG_LEVELS, 32'd1);
        send_point(32'h0000_7FFF, 32'h0000_8000, ONE_Q16);
        drain();
        cfg_write(nme_pkg::REG_LEVELS, 32'd0);
        send_point(ONE_Q16, 32'h0000_3039, COORD_MAX);
        drain();
        cfg_write(nme_pkg::REG_LEVELS, 32'd31);
        send_point(32'h0000_3039, 32'h0000_D431, 32'h0000_FFFF);
        send_point(ONE_Q16, ONE_Q16, ONE_Q16);
        drain();
        cfg_write(nme_pkg::REG_LEVELS, 32'hFFFF_FFE5);
        send_point(32'h0000_3039, 32'h0000_D431, 32'h0000_FFFF);
        drain();
        cfg_write(nme_pkg::REG_LEVELS, 32'd22);
        cfg_write(REG_UNUSED, 32'h0000_0003);
        send_point(32'h0000_A000, 32'h0000_2000, 32'h0000_FFFE);
    endtask

    task automatic test_degenerate_box();
        drain();
        cfg_write(nme_pkg::REG_BOX_MIN_X, 32'd1000);
        cfg_write(nme_pkg::REG_BOX_MAX_X, 32'd1000);
        cfg_write(nme_pkg::REG_BOX_MIN_Y, 32'd5000);
        cfg_write(nme_pkg::REG_BOX_MAX_Y, -32'sd5000);
        cfg_write(nme_pkg::REG_BOX_MIN_Z, COORD_MAX);
        cfg_write(nme_pkg::REG_BOX_MAX_Z, COORD_MAX);
        cfg_write(nme_pkg::REG_LEVELS, 32'd3);
        send_point(32'd1000, 32'd5000, COORD_MAX);
        send_point(32'd1001, 32'd5001, COORD_MIN);
        send_point(32'd999, 32'd4999, 32'd0);
    endtask

    task automatic test_full_range();
        drain();
        set_box(COORD_MIN, COORD_MAX);
        cfg_write(nme_pkg::REG_LEVELS, 32'd21);
        send_point(COORD_MIN, COORD_MAX, 32'd0);
        send_point(32'h7FFF_FFFE, 32'h8000_0001, 32'hFFFF_FFFF);
        send_point(32'h4000_0000, 32'hC000_0000, 32'd1);
    endtask

    task automatic test_random_points(input int unsigned phases, input int unsigned per_phase);
        for (int ph = 0; ph < phases; ph++)
        begin
            drain();
            rand_settings();
            src_idle = (ph % 4 == 0) || (ph % 4 == 2);
            sink_idle = (ph % 4 == 0) || (ph % 4 == 3);
            for (int n = 0; n < per_phase; n++)
                send_point(point_near(box_lo[0], box_hi[0]), point_near(box_lo[1], box_hi[1]),
                           point_near(box_lo[2], box_hi[2]));
        end
        src_idle = 1'b1;
        sink_idle = 1'b1;
    endtask

    // Code checker
    always @(posedge clk)
    begin
        logic [nme_pkg::CODE_BITS-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            codes_seen++;
            if (codes_due.size() == 0)
                log_error($sformatf("code %h with no request pending", grid_code));
            else
            begin
                want = codes_due.pop_front();
                if (grid_code !== want)
                    log_error($sformatf("grid_code %h, want %h", grid_code, want));
            end
        end
    end

    // Output backpressure: a random stall before each result while sink_idle is set
    initial
    begin
        int unsigned gap;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = sink_idle ? $urandom_range(0, 11) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial
    begin
        #3_000_000;
        $display("normalized_morton_encoder_3d regression: fail");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a] = '0;
            box_hi[a] = ONE_Q16;
        end
        grid_levels = nme_pkg::LEVELS_RESET;
        src_idle = 1'b1;
        sink_idle = 1'b1;
        errors = 0;
        points_sent = 0;
        codes_seen = 0;
        reg_writes = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unit_box();
        test_levels();
        test_degenerate_box();
        test_full_range();
        test_random_points(10, 173);

        drain();
        repeat (30) @(posedge clk);
        $display("covered %0d points over unit, degenerate, full-range and random boxes",
                 points_sent);
        $display("levels 0..31 incl. saturation, %0d codes checked, %0d register writes",
                 codes_seen, reg_writes);
        if (errors == 0 && codes_due.size() == 0)
            $display("normalized_morton_encoder_3d regression: pass");
        else
            $display("normalized_morton_encoder_3d regression: fail");
        $finish;
    end

endmodule
